>>> src/vhtd_pkg.sv
`timescale 1ns / 1ps

package vhtd_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FREQ_W     = 12;
  localparam int unsigned TOL_W      = 10;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned STAGE_W    = 2;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REG_ADDR_W = 5;

  // Default number of samples in one averaging window.
  localparam int unsigned WINDOW_LEN_DEF = 8;

  // Register reset values.
  localparam logic [FREQ_W-1:0] LEADER_FREQ_RST = 12'd1900;
  localparam logic [FREQ_W-1:0] SYNC_FREQ_RST   = 12'd1200;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST   = 10'd50;
  localparam logic [CNT_W-1:0]  LEADER_ONE_RST  = 10'd250;
  localparam logic [CNT_W-1:0]  SYNC_WIN_RST    = 10'd8;
  localparam logic [CNT_W-1:0]  LEADER_TWO_RST  = 10'd250;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_LEADER_FREQ = 3'd0,
    REG_SYNC_FREQ   = 3'd1,
    REG_TOLERANCE   = 3'd2,
    REG_LEADER_ONE  = 3'd3,
    REG_SYNC_WIN    = 3'd4,
    REG_LEADER_TWO  = 3'd5
  } reg_idx_e;

  // Detector stages, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LEAD1 = 4'b0010,
    ST_SYNC = 4'b0100,
    ST_LEAD2 = 4'b1000
  } stage_e;

  // Stage numbers as reported on the result.
  localparam logic [STAGE_W-1:0] CODE_IDLE  = 2'd0;
  localparam logic [STAGE_W-1:0] CODE_LEAD1 = 2'd1;
  localparam logic [STAGE_W-1:0] CODE_SYNC  = 2'd2;
  localparam logic [STAGE_W-1:0] CODE_LEAD2 = 2'd3;

  // Detector configuration as held in the register bank.
  typedef struct packed {
    logic [FREQ_W-1:0] leader_freq;
    logic [FREQ_W-1:0] sync_freq;
    logic [TOL_W-1:0]  match_tolerance;
    logic [CNT_W-1:0]  leader_one_windows;
    logic [CNT_W-1:0]  sync_windows;
    logic [CNT_W-1:0]  leader_two_windows;
  } cfg_t;

  // Map a one-hot stage to its reported number.
  function automatic logic [STAGE_W-1:0] stage_code(input stage_e st);
    logic [STAGE_W-1:0] code;
    case (st)
      ST_IDLE:  code = CODE_IDLE;
      ST_LEAD1: code = CODE_LEAD1;
      ST_SYNC:  code = CODE_SYNC;
      ST_LEAD2: code = CODE_LEAD2;
      default:  code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> src/vhtd_accum.sv
`timescale 1ns / 1ps

module vhtd_accum import vhtd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int unsigned SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SAMPLE_W-1:0] freq_sample_i,
  output logic                    win_valid_o,
  input  logic                    win_ready_i,
  output logic signed [SUM_W-1:0] win_sum_o
);

  localparam int unsigned FILL_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LEN - 1);

  logic signed [SUM_W-1:0] sum_q, sum_d, sum_next;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic                    win_v_q, win_v_d;
  logic signed [SUM_W-1:0] win_sum_q, win_sum_d;
  logic                    accept, last;

  assign in_ready_o = !win_v_q || win_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (fill_q == FILL_LAST);
  assign sum_next   = sum_q + SUM_W'(freq_sample_i);

  // Running sum and fill count; a full window moves to the output register.
  always_comb begin
    sum_d     = sum_q;
    fill_d    = fill_q;
    win_sum_d = win_sum_q;
    win_v_d   = win_v_q && !win_ready_i;
    if (accept) begin
      if (last) begin
        sum_d     = '0;
        fill_d    = '0;
        win_sum_d = sum_next;
        win_v_d   = 1'b1;
      end else begin
        sum_d  = sum_next;
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      fill_q  <= '0;
      win_v_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      fill_q  <= fill_d;
      win_v_q <= win_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_sum_q <= win_sum_d;
  end

  assign win_valid_o = win_v_q;
  assign win_sum_o   = win_sum_q;

endmodule

>>> src/vhtd_avg.sv
`timescale 1ns / 1ps

module vhtd_avg import vhtd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int unsigned SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sum_valid_i,
  output logic                       sum_ready_o,
  input  logic signed [SUM_W-1:0]    sum_i,
  output logic                       avg_valid_o,
  input  logic                       avg_ready_i,
  output logic signed [SAMPLE_W-1:0] avg_o
);

  // Reciprocal scaled by 2^SUM_W; the estimate is the quotient or one less.
  localparam logic [SUM_W:0]   RECIP = (SUM_W+1)'((64'd1 << SUM_W) / WINDOW_LEN);
  localparam logic [SUM_W-1:0] WLEN  = SUM_W'(WINDOW_LEN);
  localparam int unsigned      PROD_W = 2 * SUM_W + 1;

  // Estimate stage.
  logic                a_v_q;
  logic                a_neg_q;
  logic [SUM_W-1:0]    a_mag_q;
  logic [SAMPLE_W-1:0] a_est_q;
  logic                a_ready;
  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;

  // Correction stage.
  logic                       b_v_q;
  logic signed [SAMPLE_W-1:0] b_avg_q, b_avg_d;
  logic [2*SUM_W-1:0]         back_prod;
  logic [SUM_W-1:0]           rem;
  logic [SAMPLE_W-1:0]        quot;

  assign a_ready     = !b_v_q || avg_ready_i;
  assign sum_ready_o = !a_v_q || a_ready;

  // Magnitude times reciprocal gives the quotient estimate.
  assign neg  = sum_i[SUM_W-1];
  assign mag  = neg ? (~sum_i + 1'b1) : sum_i;
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);

  // Remainder check adds the missing one, then the sign is put back.
  assign back_prod = (2*SUM_W)'(a_est_q) * (2*SUM_W)'(WLEN);
  assign rem       = a_mag_q - back_prod[SUM_W-1:0];
  assign quot      = a_est_q + SAMPLE_W'(rem >= WLEN);
  assign b_avg_d   = a_neg_q ? -$signed(quot) : $signed(quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (sum_ready_o) begin
        a_v_q <= sum_valid_i;
      end
      if (a_ready) begin
        b_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready_o && sum_valid_i) begin
      a_neg_q <= neg;
      a_mag_q <= mag;
      a_est_q <= prod[SUM_W +: SAMPLE_W];
    end
    if (a_ready && a_v_q) begin
      b_avg_q <= b_avg_d;
    end
  end

  assign avg_valid_o = b_v_q;
  assign avg_o       = b_avg_q;

endmodule

>>> src/vhtd_detect.sv
`timescale 1ns / 1ps

module vhtd_detect import vhtd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       avg_valid_i,
  output logic                       avg_ready_o,
  input  logic signed [SAMPLE_W-1:0] avg_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] window_average_o,
  output logic [STAGE_W-1:0]         detect_stage_o,
  output logic                       header_found_o
);

  localparam int unsigned DIFF_W = SAMPLE_W + 2;

  stage_e            stage_q, stage_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  count_inc;
  logic              out_v_q;
  logic              found_d, found_q;
  logic [STAGE_W-1:0] code_q;
  logic signed [SAMPLE_W-1:0] avg_q;
  logic              take;
  logic              match_lead, match_sync;
  logic signed [DIFF_W-1:0] diff_lead, diff_sync;
  logic [DIFF_W-1:0] abs_lead, abs_sync;

  assign avg_ready_o = !out_v_q || out_ready_i;
  assign take        = avg_valid_i && avg_ready_o;

  // Tolerance checks against both tones.
  assign diff_lead  = DIFF_W'(avg_i) - DIFF_W'($signed({1'b0, cfg_i.leader_freq}));
  assign diff_sync  = DIFF_W'(avg_i) - DIFF_W'($signed({1'b0, cfg_i.sync_freq}));
  assign abs_lead   = diff_lead[DIFF_W-1] ? DIFF_W'(-diff_lead) : DIFF_W'(diff_lead);
  assign abs_sync   = diff_sync[DIFF_W-1] ? DIFF_W'(-diff_sync) : DIFF_W'(diff_sync);
  assign match_lead = abs_lead <= DIFF_W'(cfg_i.match_tolerance);
  assign match_sync = abs_sync <= DIFF_W'(cfg_i.match_tolerance);
  assign count_inc  = count_q + 1'b1;

  // Stage sequencing; a leader match on any miss restarts the first stage.
  always_comb begin
    stage_d = stage_q;
    count_d = count_q;
    found_d = 1'b0;
    case (stage_q)
      ST_IDLE: begin
        stage_d = match_lead ? ST_LEAD1 : ST_IDLE;
        count_d = match_lead ? CNT_W'(1) : '0;
      end
      ST_LEAD1: begin
        if (match_lead) begin
          count_d = count_inc;
          if (count_inc >= cfg_i.leader_one_windows) begin
            stage_d = ST_SYNC;
            count_d = '0;
          end
        end else begin
          stage_d = ST_IDLE;
          count_d = '0;
        end
      end
      ST_SYNC: begin
        if (match_sync) begin
          count_d = count_inc;
          if (count_inc >= cfg_i.sync_windows) begin
            stage_d = ST_LEAD2;
            count_d = '0;
          end
        end else begin
          stage_d = match_lead ? ST_LEAD1 : ST_IDLE;
          count_d = match_lead ? CNT_W'(1) : '0;
        end
      end
      ST_LEAD2: begin
        if (match_lead) begin
          count_d = count_inc;
          if (count_inc >= cfg_i.leader_two_windows) begin
            found_d = 1'b1;
            stage_d = ST_IDLE;
            count_d = '0;
          end
        end else begin
          stage_d = ST_IDLE;
          count_d = '0;
        end
      end
      default: begin
        stage_d = ST_IDLE;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_IDLE;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (take) begin
        stage_q <= stage_d;
        count_q <= count_d;
      end
      if (avg_ready_o) begin
        out_v_q <= avg_valid_i;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      avg_q   <= avg_i;
      code_q  <= stage_code(stage_d);
      found_q <= found_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign window_average_o = avg_q;
  assign detect_stage_o   = code_q;
  assign header_found_o   = found_q;

endmodule

>>> src/vis_header_tone_detector.sv
`timescale 1ns / 1ps

// A result passes the accumulator output, both divider stages and the detector register.
// Throughput: one sample per cycle unless back-pressure stalls it; one result per WINDOW_LEN samples.
// The path is a window accumulator, a two-stage reciprocal divider and the detector register.
// Reset (asynchronous, active low) clears the window, the detector stage and count,
// empties the pipeline, and loads the register defaults.
module vis_header_tone_detector import vhtd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [REG_ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] freq_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] window_average_o,
  output logic [STAGE_W-1:0]         detect_stage_o,
  output logic                       header_found_o
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  logic                       win_valid, win_ready;
  logic signed [SUM_W-1:0]    win_sum;
  logic                       avg_valid, avg_ready;
  logic signed [SAMPLE_W-1:0] avg;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[REG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_freq        <= LEADER_FREQ_RST;
      cfg_q.sync_freq          <= SYNC_FREQ_RST;
      cfg_q.match_tolerance    <= TOLERANCE_RST;
      cfg_q.leader_one_windows <= LEADER_ONE_RST;
      cfg_q.sync_windows       <= SYNC_WIN_RST;
      cfg_q.leader_two_windows <= LEADER_TWO_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEADER_FREQ: cfg_q.leader_freq        <= pwdata[FREQ_W-1:0];
        REG_SYNC_FREQ:   cfg_q.sync_freq          <= pwdata[FREQ_W-1:0];
        REG_TOLERANCE:   cfg_q.match_tolerance    <= pwdata[TOL_W-1:0];
        REG_LEADER_ONE:  cfg_q.leader_one_windows <= pwdata[CNT_W-1:0];
        REG_SYNC_WIN:    cfg_q.sync_windows       <= pwdata[CNT_W-1:0];
        REG_LEADER_TWO:  cfg_q.leader_two_windows <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_LEADER_FREQ: prdata = DATA_W'(cfg_q.leader_freq);
      REG_SYNC_FREQ:   prdata = DATA_W'(cfg_q.sync_freq);
      REG_TOLERANCE:   prdata = DATA_W'(cfg_q.match_tolerance);
      REG_LEADER_ONE:  prdata = DATA_W'(cfg_q.leader_one_windows);
      REG_SYNC_WIN:    prdata = DATA_W'(cfg_q.sync_windows);
      REG_LEADER_TWO:  prdata = DATA_W'(cfg_q.leader_two_windows);
      default:         prdata = '0;
    endcase
  end

  // Window accumulator.
  vhtd_accum #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .freq_sample_i (freq_sample_i),
    .win_valid_o   (win_valid),
    .win_ready_i   (win_ready),
    .win_sum_o     (win_sum)
  );

  // Division by the window length.
  vhtd_avg #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (win_valid),
    .sum_ready_o (win_ready),
    .sum_i       (win_sum),
    .avg_valid_o (avg_valid),
    .avg_ready_i (avg_ready),
    .avg_o       (avg)
  );

  // Tone sequence detector and result register.
  vhtd_detect u_detect (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .avg_valid_i      (avg_valid),
    .avg_ready_o      (avg_ready),
    .avg_i            (avg),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .window_average_o (window_average_o),
    .detect_stage_o   (detect_stage_o),
    .header_found_o   (header_found_o)
  );

endmodule

>>> tb/tb_vis_header_tone_detector.sv
`timescale 1ns / 1ps

module tb_vis_header_tone_detector;
  import vhtd_pkg::*;

  localparam int unsigned WIN_LEN        = WINDOW_LEN_DEF;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          LONG_STALL     = 400;
  localparam int          WATCHDOG_LIMIT = 2000;

  // Register slots past the last defined register; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [STAGE_W-1:0]         stage;
    logic                       found;
  } window_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [REG_ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] freq_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] window_average_o;
  logic [STAGE_W-1:0]         detect_stage_o;
  logic                       header_found_o;

  vis_header_tone_detector #(
    .WINDOW_LEN(WIN_LEN)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .freq_sample_i   (freq_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .window_average_o(window_average_o),
    .detect_stage_o  (detect_stage_o),
    .header_found_o  (header_found_o)
  );

  always #5 clk_i = ~clk_i;

  // Samples waiting to be sent, and window results waiting to come out.
  logic signed [SAMPLE_W-1:0] pending_samples[$];
  window_result_t             expected_windows[$];

  flow_e flow_mode = FLOW_FREE;
  int    samples_queued = 0;
  int    samples_accepted = 0;
  int    error_count = 0;
  int    quiet_cycles = 0;
  int    stall_req = 0;
  int    stall_ack = 0;
  int    stall_left = 0;
  bit    sample_taken = 1'b0;
  int    gen_fill = 0;
  int    phase_items = 0;

  // Detector copy: configuration, window accumulator, stage and match count.
  cfg_t model_cfg = '{
    leader_freq:        LEADER_FREQ_RST,
    sync_freq:          SYNC_FREQ_RST,
    match_tolerance:    TOLERANCE_RST,
    leader_one_windows: LEADER_ONE_RST,
    sync_windows:       SYNC_WIN_RST,
    leader_two_windows: LEADER_TWO_RST
  };
  longint             acc_sum = 0;
  int unsigned        acc_fill = 0;
  logic [STAGE_W-1:0] det_stage = CODE_IDLE;
  logic [CNT_W-1:0]   det_count = '0;

  function automatic bit near_tone(input int avg, input logic [FREQ_W-1:0] tone);
    int diff;
    diff = avg - int'(tone);
    if (diff < 0) diff = -diff;
    return diff <= int'(model_cfg.match_tolerance);
  endfunction

  // A window that breaks the sequence restarts leader one if it carries the leader tone.
  function automatic void fall_back(input int avg);
    if (near_tone(avg, model_cfg.leader_freq)) begin
      det_stage = CODE_LEAD1;
      det_count = 10'd1;
    end else begin
      det_stage = CODE_IDLE;
      det_count = '0;
    end
  endfunction

  // Fold one sample into the window; a full window updates the detector.
  function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] sample);
    int             avg;
    logic           found;
    window_result_t res;
    acc_sum = acc_sum + sample;
    acc_fill++;
    if (acc_fill < WIN_LEN) return;
    avg = int'(acc_sum / longint'(WIN_LEN));
    acc_sum = 0;
    acc_fill = 0;
    found = 1'b0;
    case (det_stage)
      CODE_IDLE: begin
        fall_back(avg);
      end
      CODE_LEAD1: begin
        if (near_tone(avg, model_cfg.leader_freq)) begin
          det_count = det_count + 10'd1;
          if (det_count >= model_cfg.leader_one_windows) begin
            det_stage = CODE_SYNC;
            det_count = '0;
          end
        end else begin
          fall_back(avg);
        end
      end
      CODE_SYNC: begin
        if (near_tone(avg, model_cfg.sync_freq)) begin
          det_count = det_count + 10'd1;
          if (det_count >= model_cfg.sync_windows) begin
            det_stage = CODE_LEAD2;
            det_count = '0;
          end
        end else begin
          fall_back(avg);
        end
      end
      default: begin
        if (near_tone(avg, model_cfg.leader_freq)) begin
          det_count = det_count + 10'd1;
          if (det_count >= model_cfg.leader_two_windows) begin
            found = 1'b1;
            det_stage = CODE_IDLE;
            det_count = '0;
          end
        end else begin
          fall_back(avg);
        end
      end
    endcase
    res.average = avg[SAMPLE_W-1:0];
    res.stage = det_stage;
    res.found = found;
    expected_windows.push_back(res);
  endfunction

  function automatic bit sender_pauses();
    case (flow_mode)
      FLOW_SRC_GAPS: return $urandom_range(99) < 56;
      FLOW_BOTH:     return $urandom_range(99) < 9;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_ready();
    case (flow_mode)
      FLOW_SINK_STALLS: return $urandom_range(99) >= 56;
      FLOW_BOTH:        return $urandom_range(99) >= 9;
      default:          return 1'b1;
    endcase
  endfunction

  // Sample driver: holds valid and data until the transfer happens.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || sample_taken) begin
      if (pending_samples.size() != 0 && !sender_pauses()) begin
        in_valid_i <= 1'b1;
        freq_sample_i <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (stall_ack != stall_req) begin
      stall_ack <= stall_req;
      stall_left <= LONG_STALL;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= receiver_ready();
    end
  end

  // Monitor: predicts on each sample transfer, checks each result transfer.
  always @(posedge clk_i) begin
    window_result_t exp_res;
    int             errs;
    errs = 0;
    sample_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      absorb_sample(freq_sample_i);
      samples_accepted <= samples_accepted + 1;
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_windows.size() == 0) begin
        $error("unexpected window result: average %0d stage %0d found %0b",
               window_average_o, detect_stage_o, header_found_o);
        errs = errs + 1;
      end else begin
        exp_res = expected_windows.pop_front();
        if (window_average_o !== exp_res.average) begin
          $error("window_average: expected %0d, got %0d", exp_res.average, window_average_o);
          errs = errs + 1;
        end
        if (detect_stage_o !== exp_res.stage) begin
          $error("detect_stage: expected %0d, got %0d", exp_res.stage, detect_stage_o);
          errs = errs + 1;
        end
        if (header_found_o !== exp_res.found) begin
          $error("header_found: expected %0b, got %0b", exp_res.found, header_found_o);
          errs = errs + 1;
        end
      end
    end
    if (errs != 0) begin
      error_count <= error_count + errs;
    end
    // Watchdog on cycles without any transfer.
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("** vis_header_tone_detector: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input int value);
    pending_samples.push_back(value[SAMPLE_W-1:0]);
    samples_queued++;
    gen_fill = (gen_fill + 1) % WIN_LEN;
    phase_items++;
  endtask

  function automatic int random_sample();
    case ($urandom_range(9))
      0:       return 32767;
      1:       return -32768;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // One window whose samples sum to about WIN_LEN times the target, aligned to a boundary.
  task automatic push_window(input int target);
    int vals[WIN_LEN];
    int t;
    int lim;
    int spread;
    int n;
    int r;
    while (gen_fill != 0) push_sample(random_sample());
    t = target;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    case ($urandom_range(3))
      0:       spread = 0;
      1:       spread = 20;
      2:       spread = 2000;
      default: spread = 32767;
    endcase
    lim = 32767 - t;
    if (t + 32768 < lim) lim = t + 32768;
    if (spread < lim) lim = spread;
    for (int k = 0; k + 1 < WIN_LEN; k += 2) begin
      n = int'($urandom_range(lim));
      vals[k] = t + n;
      vals[k+1] = t - n;
    end
    if (WIN_LEN % 2 != 0) vals[WIN_LEN-1] = t;
    // A small remainder exercises truncation toward zero.
    if ($urandom_range(2) == 0) begin
      r = int'($urandom_range(14)) - 7;
      if (vals[0] + r <= 32767 && vals[0] + r >= -32768) vals[0] = vals[0] + r;
    end
    for (int k = 0; k < WIN_LEN; k++) push_sample(vals[k]);
  endtask

  task automatic tone_window(input logic [FREQ_W-1:0] tone, input bit hit);
    int tol;
    int d;
    tol = int'(model_cfg.match_tolerance);
    if (hit) begin
      case ($urandom_range(3))
        0:       d = tol;
        1:       d = -tol;
        default: d = int'($urandom_range(2 * tol)) - tol;
      endcase
    end else begin
      d = tol + 1 + int'($urandom_range(200));
      if ($urandom_range(1)) d = -d;
    end
    push_window(int'(tone) + d);
  endtask

  task automatic noise_window();
    for (int k = 0; k < WIN_LEN; k++) push_sample(random_sample());
  endtask

  function automatic int header_windows();
    int n1;
    int n2;
    int n3;
    n1 = (model_cfg.leader_one_windows < 2) ? 2 : int'(model_cfg.leader_one_windows);
    n2 = (model_cfg.sync_windows < 1) ? 1 : int'(model_cfg.sync_windows);
    n3 = (model_cfg.leader_two_windows < 1) ? 1 : int'(model_cfg.leader_two_windows);
    return n1 + n2 + n3;
  endfunction

  // Leader, sync and leader again; a broken run spoils one window on the way.
  task automatic header_run(input bit broken);
    int n1;
    int n2;
    int total;
    int cut;
    logic [FREQ_W-1:0] tone;
    n1 = (model_cfg.leader_one_windows < 2) ? 2 : int'(model_cfg.leader_one_windows);
    n2 = (model_cfg.sync_windows < 1) ? 1 : int'(model_cfg.sync_windows);
    total = header_windows();
    cut = broken ? int'($urandom_range(total - 1)) : total;
    for (int k = 0; k < total; k++) begin
      tone = (k < n1 || k >= n1 + n2) ? model_cfg.leader_freq : model_cfg.sync_freq;
      if (k != cut) begin
        tone_window(tone, 1'b1);
      end else if (k >= n1 && k < n1 + n2 && $urandom_range(1)) begin
        // Leader tone where the sync is due restarts the first stage.
        tone_window(model_cfg.leader_freq, 1'b1);
      end else begin
        tone_window(tone, 1'b0);
      end
    end
  endtask

  task automatic random_traffic(input int n_items);
    int pick;
    phase_items = 0;
    while (phase_items < n_items) begin
      pick = int'($urandom_range(99));
      if (pick < 55 && header_windows() <= 40) begin
        header_run($urandom_range(3) == 0);
      end else if (pick < 80) begin
        tone_window($urandom_range(1) ? model_cfg.leader_freq : model_cfg.sync_freq,
                    $urandom_range(3) != 0);
      end else if (pick < 92) begin
        noise_window();
      end else begin
        // Stray samples leave a partial window behind.
        repeat ($urandom_range(WIN_LEN - 1, 1)) push_sample(random_sample());
      end
    end
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] word;
    mask = '1;
    if (idx == REG_LEADER_FREQ || idx == REG_SYNC_FREQ) mask = mask >> (DATA_W - FREQ_W);
    else mask = mask >> (DATA_W - CNT_W);
    word = value & mask;
    if ($urandom_range(1)) word = word | ($urandom() & ~mask);
    case (idx)
      REG_LEADER_FREQ: model_cfg.leader_freq = word[FREQ_W-1:0];
      REG_SYNC_FREQ:   model_cfg.sync_freq = word[FREQ_W-1:0];
      REG_TOLERANCE:   model_cfg.match_tolerance = word[TOL_W-1:0];
      REG_LEADER_ONE:  model_cfg.leader_one_windows = word[CNT_W-1:0];
      REG_SYNC_WIN:    model_cfg.sync_windows = word[CNT_W-1:0];
      REG_LEADER_TWO:  model_cfg.leader_two_windows = word[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = word;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_all(input int unsigned lead, input int unsigned sync,
                             input int unsigned tol, input int unsigned n_one,
                             input int unsigned n_sync, input int unsigned n_two);
    write_reg(REG_LEADER_FREQ, lead);
    write_reg(REG_SYNC_FREQ, sync);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_LEADER_ONE, n_one);
    write_reg(REG_SYNC_WIN, n_sync);
    write_reg(REG_LEADER_TWO, n_two);
  endtask

  // Wait until every sample is through and every window result has come out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (samples_accepted != samples_queued || expected_windows.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: field extremes, leader entry, sync tone from stage one.
    flow_mode = FLOW_FREE;
    repeat (WIN_LEN) push_sample(32767);
    repeat (WIN_LEN) push_sample(-32768);
    repeat (WIN_LEN) push_sample(int'(LEADER_FREQ_RST));
    repeat (WIN_LEN) push_sample(int'(SYNC_FREQ_RST));
    wait_drained();

    // Short thresholds, second leader threshold of zero; tolerance boundaries and restarts.
    program_all(1900, 1200, 50, 2, 1, 0);
    push_window(1900 + 50);
    push_window(1900 - 50);
    push_window(1900);
    push_window(1900 + 51);
    header_run(1'b0);
    random_traffic(100);
    wait_drained();

    // Extreme tones and widest tolerance, sender gaps.
    program_all(0, 4095, 1023, 3, 2, 3);
    flow_mode = FLOW_SRC_GAPS;
    random_traffic(120);
    wait_drained();

    // Opposite tones and zero tolerance, receiver stalls; writes past the last register.
    program_all(4095, 0, 0, 1, 1, 1);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    flow_mode = FLOW_SINK_STALLS;
    random_traffic(120);
    wait_drained();

    // Random settings, both sides idling.
    program_all($urandom_range(4095), $urandom_range(4095), $urandom_range(300),
                $urandom_range(4), $urandom_range(4), $urandom_range(4));
    flow_mode = FLOW_BOTH;
    random_traffic(120);
    wait_drained();

    // Largest thresholds; the receiver holds off while samples keep coming.
    program_all(1900, 1200, 100, 1023, 1023, 1023);
    flow_mode = FLOW_FREE;
    random_traffic(200);
    stall_req = stall_req + 1;
    wait_drained();

    // All thresholds zero.
    program_all($urandom_range(4095), $urandom_range(4095), $urandom_range(200), 0, 0, 0);
    flow_mode = FLOW_BOTH;
    random_traffic(100);
    wait_drained();

    if (error_count == 0 && expected_windows.size() == 0) begin
      $display("** vis_header_tone_detector: PASSED **");
    end else begin
      $display("** vis_header_tone_detector: FAILED **");
    end
    $finish;
  end

endmodule
